[rtl/window_median_filter_unit_assert.svh]
// Assertion macros for the window median filter.
// Depends on nothing; included by the top level.
`ifndef WINDOW_MEDIAN_FILTER_UNIT_ASSERT_SVH
`define WINDOW_MEDIAN_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define WMF_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define WMF_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define WMF_ASSERT_IMP(label, clk, rst, pre, post)
`define WMF_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

[rtl/wmf_pkg.sv]
// Shared types and constants of the window median filter.
// No dependencies.
`default_nettype none
package wmf_pkg;
   localparam int MaxWidth   = 1024;
   localparam int MaxWindow  = 15;
   localparam int StoreRows  = 16;
   localparam int HeightCap  = 4096;
   localparam int ColBits    = $clog2(MaxWidth);
   localparam int RowBits    = $clog2(StoreRows);
   localparam int AddrBits   = ColBits + RowBits;
   localparam int HalfLim1   = (MaxWindow - 1) / 2;
   localparam int HalfLim2   = (StoreRows - 2) / 2;
   localparam int HalfMax    = (HalfLim1 < HalfLim2) ? HalfLim1 : HalfLim2;
   localparam int CntBits    = $clog2((2 * HalfMax + 1) * (2 * HalfMax + 1) + 1);
   localparam logic [22:0] SeenCap = 23'h7FFFFF;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_WINDOW = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic       is_flush;
      logic [7:0] pixel_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] median_out;
      logic       last_pixel;
   } rsp_payload_type;
endpackage
`default_nettype wire

[rtl/wmf_stream_if.sv]
// Valid/ready stream channel carrying one payload beat.
// Depends on nothing; payload type is given per instance.
`default_nettype none
interface wmf_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/window_median_filter_unit.sv]
// Top level of the window median filter: line store, counters and the
// bitwise rank-selection sequencer. Depends on wmf_pkg, wmf_stream_if and
// window_median_filter_unit_assert.svh.
//
//  channel | dir | payload
//  req     | in  | is_flush, pixel_in
//  rsp     | out | median_out, last_pixel
//  csr     | in  | csr_we, csr_index, csr_wdata
//
// A flush tick dropped inside the image is taken without leaving idle; any
// other item that yields no result passes the start state and returns to
// idle. An item that yields a result runs a radix-2 rank select: 8 bit
// passes, each a scan of the clipped window through the single line store
// read port, one entry per cycle.
// A width write re-derives the write and output positions by two 23-step
// restoring divisions; req stays low until both are done.
// Reset is synchronous; the line store is not cleared. A stalled result
// holds in the output register while the next item is taken; a further
// result holds in the sequencer until the register frees.
`default_nettype none
`include "window_median_filter_unit_assert.svh"
module window_median_filter_unit import wmf_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   wmf_stream_if.sink   req,
   wmf_stream_if.source rsp,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [12:0] csr_wdata
);
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_START = 8'b00000010,
      ST_SCAN  = 8'b00000100,
      ST_DRAIN = 8'b00001000,
      ST_DEC   = 8'b00010000,
      ST_OUT   = 8'b00100000,
      ST_DINIT = 8'b01000000,
      ST_DIV   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [3:0]  window_ff;
   logic [22:0] seen_ff, seen_in;
   logic [22:0] sent_ff, sent_in;
   logic [ColBits-1:0] wcol_ff, wcol_in;   // write position
   logic [12:0] wrow_ff, wrow_in;
   logic [ColBits-1:0] pcol_ff, pcol_in;   // output position
   logic [12:0] prow_ff, prow_in;
   logic [12:0] r0_ff, r1_ff, r_ff;
   logic [ColBits-1:0] c0_ff, c1_ff, c_ff;
   logic [7:0]  prefix_ff;                 // decided bits of the median
   logic [2:0]  bit_ff;
   logic [CntBits-1:0] tgt_ff, cnt_lo_ff, total_n_ff;
   logic        rd_vld_ff;
   logic        last_ff;
   logic [7:0]  rdata_ff;
   logic [7:0]  line_store [MaxWidth*StoreRows];
   rsp_payload_type rsp_ff;
   logic        rsp_vld_ff;
   // position divider: quotient shifts in where the dividend shifts out
   logic [22:0] div_q_ff;
   logic [ColBits-1:0] div_rem_ff;
   logic [4:0]  div_step_ff;
   logic        div_sel_ff;                // 0: write position, 1: output

   // effective configuration
   logic [10:0] w_eff;
   logic [12:0] h_eff;
   logic [2:0]  half;
   logic [22:0] total;
   logic [22:0] delay;
   always_comb begin
      w_eff = (width_ff == '0) ? 11'd1 :
              (width_ff > 11'(MaxWidth)) ? 11'(MaxWidth) : width_ff;
      h_eff = (height_ff == '0) ? 13'd1 :
              (height_ff > 13'(HeightCap)) ? 13'(HeightCap) : height_ff;
      half  = (window_ff[3:1] > 3'(HalfMax)) ? 3'(HalfMax) : window_ff[3:1];
   end
   // follow a register write at once
   assign total = 23'(w_eff) * 23'(h_eff);
   assign delay = 23'(half) * 23'(w_eff) + 23'(half);

   wire accept = req.valid && req.ready;
   wire in_img = seen_ff < total;
   wire writes = accept && in_img && !req.payload.is_flush;
   wire counts = accept && (!in_img || !req.payload.is_flush);
   wire [22:0] seen_nx = (seen_ff < SeenCap) ? seen_ff + 23'd1 : seen_ff;
   wire emit_go = (sent_ff < total) && (seen_ff > sent_ff + delay);
   wire out_go = !rsp_vld_ff || rsp.ready;
   wire width_wr = csr_we && (csr_index == REG_WIDTH);

   assign req.ready = (state_ff == ST_IDLE);

   // one restoring step of position / w_eff
   wire [ColBits:0] div_trial = {div_rem_ff, div_q_ff[22]};
   wire div_ge = div_trial >= w_eff;
   wire [ColBits-1:0] div_rem_nx = div_ge ? ColBits'(div_trial - w_eff) :
                                            div_trial[ColBits-1:0];
   wire [22:0] div_q_nx = {div_q_ff[21:0], div_ge};

   // window bounds for output position
   logic [12:0] r0_c, r1_c;
   logic [ColBits-1:0] c0_c, c1_c;
   always_comb begin
      r0_c = (prow_ff >= 13'(half)) ? prow_ff - 13'(half) : '0;
      r1_c = (prow_ff + 13'(half) < h_eff) ? prow_ff + 13'(half) : h_eff - 13'd1;
      c0_c = (11'(pcol_ff) >= 11'(half)) ? ColBits'(11'(pcol_ff) - 11'(half)) : '0;
      c1_c = (11'(pcol_ff) + 11'(half) < w_eff) ?
             ColBits'(11'(pcol_ff) + 11'(half)) : ColBits'(w_eff - 11'd1);
   end

   wire scan_end = (r_ff == r1_ff) && (c_ff == c1_ff);
   wire [AddrBits-1:0] raddr = {r_ff[RowBits-1:0], c_ff};

   always_ff @(posedge clock) begin
      if (writes)
         line_store[{wrow_ff[RowBits-1:0], wcol_ff}] <= req.payload.pixel_in;
      rdata_ff <= line_store[raddr];
   end

   // candidate: prefix with current bit set; count values below it
   wire [7:0] bitmask  = 8'hFF << bit_ff;
   wire [7:0] cand     = prefix_ff | (8'd1 << bit_ff);
   wire       below    = (rdata_ff & bitmask) < cand;

   always_comb begin
      state_in = state_ff;
      seen_in = seen_ff;  sent_in = sent_ff;
      wcol_in = wcol_ff;  wrow_in = wrow_ff;
      pcol_in = pcol_ff;  prow_in = prow_ff;
      if (counts) seen_in = seen_nx;
      if (writes) begin
         if (11'(wcol_ff) == w_eff - 11'd1) begin
            wcol_in = '0; wrow_in = wrow_ff + 13'd1;
         end else begin
            wcol_in = wcol_ff + 1'b1;
         end
      end
      unique case (state_ff)
         ST_IDLE:  if (accept && counts) state_in = ST_START;
         ST_START: state_in = emit_go ? ST_SCAN : ST_IDLE;
         ST_SCAN:  if (scan_end) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_DEC;
         ST_DEC:   state_in = (bit_ff == 3'd0) ? ST_OUT : ST_SCAN;
         ST_OUT: begin
            // hold until the output register is free
            if (out_go) begin
               state_in = ST_IDLE;
               sent_in = sent_ff + 23'd1;
               if (11'(pcol_ff) == w_eff - 11'd1) begin
                  pcol_in = '0; prow_in = prow_ff + 13'd1;
               end else begin
                  pcol_in = pcol_ff + 1'b1;
               end
            end
         end
         ST_DINIT: state_in = ST_DIV;
         ST_DIV: begin
            if (div_step_ff == 5'd22) begin
               if (!div_sel_ff) begin
                  wrow_in = div_q_nx[12:0]; wcol_in = div_rem_nx;
                  state_in = ST_DINIT;
               end else begin
                  prow_in = div_q_nx[12:0]; pcol_in = div_rem_nx;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // a new width moves both positions: re-derive them
      if (width_wr) state_in = ST_DINIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         width_ff <= 11'd1024; height_ff <= 13'd1024; window_ff <= 4'd7;
         seen_ff <= '0; sent_ff <= '0;
         wcol_ff <= '0; wrow_ff <= '0; pcol_ff <= '0; prow_ff <= '0;
         rsp_vld_ff <= 1'b0; rd_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seen_ff <= seen_in; sent_ff <= sent_in;
         wcol_ff <= wcol_in; wrow_ff <= wrow_in;
         pcol_ff <= pcol_in; prow_ff <= prow_in;
         rd_vld_ff <= (state_ff == ST_SCAN);
         if (csr_we) begin
            unique case (csr_index)
               REG_WIDTH:  width_ff  <= csr_wdata[10:0];
               REG_HEIGHT: height_ff <= csr_wdata;
               REG_WINDOW: window_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (state_ff == ST_OUT && out_go) rsp_vld_ff <= 1'b1;
         else if (rsp.ready) rsp_vld_ff <= 1'b0;
      end
   end

   // datapath of the rank selector and the position divider
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_START: begin
            r0_ff <= r0_c; r1_ff <= r1_c; c0_ff <= c0_c; c1_ff <= c1_c;
            r_ff <= r0_c; c_ff <= c0_c;
            prefix_ff <= '0; bit_ff <= 3'd7;
            cnt_lo_ff <= '0; tgt_ff <= '0; total_n_ff <= '0;
            last_ff <= (sent_ff + 23'd1 == total);
         end
         ST_SCAN: begin
            if (c_ff == c1_ff) begin
               c_ff <= c0_ff; r_ff <= r_ff + 13'd1;
            end else begin
               c_ff <= c_ff + 1'b1;
            end
         end
         ST_DEC: begin
            // target = count/2; count known after the first pass
            r_ff <= r0_ff; c_ff <= c0_ff;
            if (cnt_lo_ff > tgt_ff) begin
               // median lies below candidate: keep bit clear
            end else begin
               prefix_ff <= cand;
            end
            cnt_lo_ff <= '0;
            if (bit_ff != 3'd0) bit_ff <= bit_ff - 3'd1;
         end
         ST_OUT: begin
            if (out_go) begin
               rsp_ff.median_out <= prefix_ff;
               rsp_ff.last_pixel <= last_ff;
            end
         end
         ST_DINIT: begin
            div_q_ff <= div_sel_ff ? sent_ff : seen_ff;
            div_rem_ff <= '0;
            div_step_ff <= '0;
         end
         ST_DIV: begin
            div_q_ff <= div_q_nx;
            div_rem_ff <= div_rem_nx;
            div_step_ff <= div_step_ff + 5'd1;
         end
         default: ;
      endcase
      if (width_wr) div_sel_ff <= 1'b0;
      else if (state_ff == ST_DIV && div_step_ff == 5'd22) div_sel_ff <= 1'b1;
      if (rd_vld_ff) begin
         cnt_lo_ff <= cnt_lo_ff + CntBits'(below);
         if (bit_ff == 3'd7) total_n_ff <= total_n_ff + 1'b1;
      end
      // the last window pixel is still being counted in this cycle
      if (state_ff == ST_DRAIN && bit_ff == 3'd7)
         tgt_ff <= (total_n_ff + CntBits'(1)) >> 1;
   end

   assign rsp.valid   = rsp_vld_ff;
   assign rsp.payload = rsp_ff;

   `WMF_ASSERT_IMP(a_ready_idle, clock, reset, req.ready, state_ff == ST_IDLE)
   `WMF_ASSERT_NXT(a_hold_rsp, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
   `WMF_ASSERT_NXT(a_rsp_stable, clock, reset, rsp.valid && !rsp.ready, $stable(rsp.payload))
endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench for window_median_filter_unit: a predictor of the clipped-window median runs
// beside the block and every result beat is compared against it, or against the given answer in the directed rows.
// Depends on wmf_pkg and wmf_stream_if from the RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import wmf_pkg::*;

   localparam int IdleLimit = 20000;

   typedef struct {
      logic       flush;
      logic [7:0] pix;
      logic       has;
      logic [7:0] med;
      logic       last;
   } directed_beat_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [12:0] csr_wdata;

   wmf_stream_if #(.payload_type(req_payload_type)) req_if ();
   wmf_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   window_median_filter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the block: line store, counters and registers.
   logic [7:0]  pix_store [MaxWidth * StoreRows];
   int unsigned seen_count;
   int unsigned sent_count;
   logic [10:0] cfg_width;
   logic [12:0] cfg_height;
   logic [3:0]  cfg_window;

   rsp_payload_type   median_q [$];
   directed_beat_type directed_beats [$];
   bit                in_directed;
   int                directed_pos;
   int                fail_count;
   int                idle_cycles;
   int                stall_run;
   int                calm_run;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Step the shadow with one accepted beat; return 1 when it yields a median.
   function automatic bit filter_step(input req_payload_type beat, output rsp_payload_type res);
      int unsigned w, ht, h, total, delay, p, row, col, r0, r1, c0, c1, cnt, acc, r, c, v;
      int unsigned hist [256];
      res = '0;
      w = (cfg_width == 0) ? 1 : ((cfg_width > MaxWidth) ? MaxWidth : cfg_width);
      ht = (cfg_height == 0) ? 1 : ((cfg_height > HeightCap) ? HeightCap : cfg_height);
      h = cfg_window >> 1;
      if (h > HalfMax) h = HalfMax;
      total = w * ht;
      delay = h * w + h;
      if (seen_count < total) begin
         // Drop flush ticks that arrive before the image is complete.
         if (beat.is_flush) return 1'b0;
         pix_store[((seen_count / w) % StoreRows) * MaxWidth + (seen_count % w)] = beat.pixel_in;
      end
      if (seen_count < SeenCap) seen_count++;
      if (sent_count >= total || seen_count <= sent_count + delay) return 1'b0;
      p = sent_count;
      row = p / w;
      col = p % w;
      r0 = (row >= h) ? row - h : 0;
      r1 = (row + h < ht) ? row + h : ht - 1;
      c0 = (col >= h) ? col - h : 0;
      c1 = (col + h < w) ? col + h : w - 1;
      for (v = 0; v < 256; v++) hist[v] = 0;
      cnt = 0;
      for (r = r0; r <= r1; r++) begin
         for (c = c0; c <= c1; c++) begin
            hist[pix_store[(r % StoreRows) * MaxWidth + c]]++;
            cnt++;
         end
      end
      // Upper middle for an even count.
      acc = 0;
      res.median_out = 8'd255;
      for (v = 0; v < 256; v++) begin
         acc += hist[v];
         if (acc > cnt / 2) begin
            res.median_out = v[7:0];
            break;
         end
      end
      res.last_pixel = (p + 1 == total);
      sent_count++;
      return 1'b1;
   endfunction

   // Scoreboard: check result beats first, then queue what the new request beat yields.
   always @(posedge clock) begin
      rsp_payload_type exp_beat;
      rsp_payload_type got_beat;
      bit              made;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got_beat = rsp_if.payload;
            if (median_q.size() == 0) begin
               $display("%0t: unexpected median beat, expected none, actual %h/%b", $time,
                        got_beat.median_out, got_beat.last_pixel);
               fail_count++;
            end else begin
               exp_beat = median_q.pop_front();
               if (got_beat.median_out !== exp_beat.median_out) begin
                  $display("%0t: median_out mismatch, expected %h, actual %h", $time,
                           exp_beat.median_out, got_beat.median_out);
                  fail_count++;
               end
               if (got_beat.last_pixel !== exp_beat.last_pixel) begin
                  $display("%0t: last_pixel mismatch, expected %b, actual %b", $time,
                           exp_beat.last_pixel, got_beat.last_pixel);
                  fail_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            made = filter_step(req_if.payload, exp_beat);
            // Directed rows carry their own answer; the shadow still advances.
            if (in_directed) begin
               made = directed_beats[directed_pos].has;
               exp_beat.median_out = directed_beats[directed_pos].med;
               exp_beat.last_pixel = directed_beats[directed_pos].last;
               directed_pos++;
            end
            if (made) median_q.insert(median_q.size(), exp_beat);
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IdleLimit) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Receiver: stall in random runs, with calm stretches of full throughput.
   always @(posedge clock) begin
      if (stall_run > 0) begin
         rsp_if.ready <= 1'b0;
         stall_run <= stall_run - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (calm_run > 0) begin
            calm_run <= calm_run - 1;
         end else if ($urandom_range(0, 5) == 0) begin
            stall_run <= $urandom_range(1, 30);
         end else if ($urandom_range(0, 40) == 0) begin
            calm_run <= $urandom_range(50, 400);
         end
      end
   end

   // Hold valid and the beat until it is taken.
   task automatic drive_beat(input logic flush, input logic [7:0] pix);
      req_if.valid <= 1'b1;
      req_if.payload <= '{is_flush: flush, pixel_in: pix};
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Wait for every expected median, then let an item without a result finish.
   // Advance the clock first so the last accepted beat is already queued.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (median_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // Write all three registers back to back; the block must be idle.
   task automatic set_geometry(input logic [12:0] w, input logic [12:0] ht,
                               input logic [12:0] k);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= REG_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= REG_HEIGHT;
      csr_wdata <= ht;
      @(posedge clock);
      csr_index <= REG_WINDOW;
      csr_wdata <= k;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_width = w[10:0];
      cfg_height = ht;
      cfg_window = k[3:0];
   endtask

   // One setting: n_pix pixels in bursts, with a few flush ticks mixed in.
   // A negative height picks one tall enough to keep the image open.
   task automatic run_phase(input int w, input int ht, input int k, input int n_pix,
                            input int flush_pct, input bit hold_mid);
      int         weff;
      int         sent_pix;
      int         burst_left;
      logic       flush;
      logic [7:0] pix;
      weff = (w == 0) ? 1 : ((w > MaxWidth) ? MaxWidth : w);
      if (ht < 0) begin
         ht = (seen_count + n_pix) / weff + 20;
         if (ht > HeightCap) ht = HeightCap;
      end
      set_geometry(13'(w), 13'(ht), 13'(k));
      sent_pix = 0;
      burst_left = 0;
      while (sent_pix < n_pix) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
               req_if.valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
         end
         if (hold_mid && sent_pix == n_pix / 2) begin
            hold_mid = 1'b0;
            wait_drained();
         end
         flush = ($urandom_range(0, 99) < flush_pct);
         pix = ($urandom_range(0, 7) == 0) ? {8{$urandom_range(0, 1) == 1}} : 8'($urandom);
         drive_beat(flush, pix);
         burst_left--;
         if (!flush) sent_pix++;
      end
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_WIDTH;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      stall_run = 0;
      calm_run = 0;
      fail_count = 0;
      idle_cycles = 0;
      seen_count = 0;
      sent_count = 0;
      cfg_width = 11'd1024;
      cfg_height = 13'd1024;
      cfg_window = 4'd7;
      in_directed = 1'b0;
      directed_pos = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: 4x2 image, window 1, so each median is the pixel itself.
      // Flush ticks inside the image are dropped and yield nothing.
      directed_beats = '{
         '{1'b0, 8'h00, 1'b1, 8'h00, 1'b0},
         '{1'b1, 8'hFF, 1'b0, 8'h00, 1'b0},
         '{1'b0, 8'hFF, 1'b1, 8'hFF, 1'b0},
         '{1'b0, 8'h80, 1'b1, 8'h80, 1'b0},
         '{1'b0, 8'h01, 1'b1, 8'h01, 1'b0},
         '{1'b1, 8'h00, 1'b0, 8'h00, 1'b0},
         '{1'b0, 8'hFE, 1'b1, 8'hFE, 1'b0},
         '{1'b0, 8'h55, 1'b1, 8'h55, 1'b0},
         '{1'b0, 8'hAA, 1'b1, 8'hAA, 1'b0},
         '{1'b0, 8'h7F, 1'b1, 8'h7F, 1'b1}
      };
      set_geometry(13'd4, 13'd2, 13'd1);
      in_directed = 1'b1;
      foreach (directed_beats[i]) drive_beat(directed_beats[i].flush, directed_beats[i].pix);
      wait_drained();
      in_directed = 1'b0;

      // Fill the store with window 1 so no later window reads an unwritten entry:
      // oversized width and height saturate, then 16-wide rows cover every store row.
      run_phase(2047, 8191, 1, 40, 5, 1'b0);
      run_phase(16, -1, 1, 288, 5, 1'b0);

      // Varied settings, widths kept within the filled columns.
      run_phase(0, 4096, 15, 40, 5, 1'b0);
      run_phase(16, -1, 15, 150, 5, 1'b0);
      run_phase(7, -1, 4, 120, 5, 1'b1);
      run_phase(3, -1, 2, 80, 10, 1'b0);
      run_phase(16, -1, 0, 60, 5, 1'b0);
      run_phase(11, -1, 9, 100, 5, 1'b0);

      // Zero height acts as one row: the image is already complete, so
      // pixels count as flush ticks and nothing more comes out.
      run_phase(16, 0, 8, 20, 30, 1'b0);

      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire
